/* src/tfe_pkg.sv */
package tfe_pkg;

  // Sizing of the tables
  localparam int MAX_STATES  = 256;
  localparam int MAX_INPUTS  = 16;
  localparam int TIME_BITS   = 16;

  localparam int STATE_W     = 8;
  localparam int SYM_W       = 4;
  localparam int OSYM_W      = 8;
  localparam int TLEN_W      = 16;
  localparam int FUNC_W      = 3;
  localparam int NSTATES_W   = 9;
  localparam int NINPUTS_W   = 5;
  localparam int NOUTPUTS_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int TRANS_DEPTH = MAX_STATES * MAX_INPUTS;
  localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
  localparam int TIME_AW     = $clog2(MAX_STATES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_LOAD_TRANS = 3'd0,
    OP_LOAD_TIME  = 3'd1,
    OP_RESTART    = 3'd2,
    OP_APPLY      = 3'd3,
    OP_TICK       = 3'd4
  } tfe_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STATES    = 2'd0,
    REG_NUM_INPUTS    = 2'd1,
    REG_NUM_OUTPUTS   = 2'd2,
    REG_RESTART_STATE = 2'd3
  } tfe_reg_e;

  typedef enum logic {
    BK_ISSUE,
    BK_FINISH
  } tfe_bk_state_e;

  typedef struct packed {
    logic [NSTATES_W-1:0]  num_states;
    logic [NINPUTS_W-1:0]  num_inputs;
    logic [NOUTPUTS_W-1:0] num_outputs;
    logic [STATE_W-1:0]    restart_state;
  } tfe_cfg_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    tfe_op_e              op;
    logic                 bad;
    logic [STATE_W-1:0]   state_index;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   target;
    logic [OSYM_W-1:0]    out_symbol;
    logic [TIME_BITS-1:0] limit;
  } tfe_item_t;

  typedef struct packed {
    logic      valid;
    tfe_item_t item;
  } tfe_queue_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [OSYM_W-1:0]  out_symbol;
  } tfe_trans_t;

  typedef struct packed {
    logic [STATE_W-1:0]   expiry;
    logic [TIME_BITS-1:0] limit;
  } tfe_time_t;

  function automatic logic [NSTATES_W-1:0] state_bound(tfe_cfg_t cfg);
    logic [NSTATES_W-1:0] lim;
    lim = NSTATES_W'(MAX_STATES);
    return (cfg.num_states < lim) ? cfg.num_states : lim;
  endfunction

  function automatic logic [NINPUTS_W-1:0] input_bound(tfe_cfg_t cfg);
    logic [NINPUTS_W-1:0] lim;
    lim = NINPUTS_W'(MAX_INPUTS);
    return (cfg.num_inputs < lim) ? cfg.num_inputs : lim;
  endfunction

endpackage

/* src/tfe_front.sv */
module tfe_front import tfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfe_cfg_t            cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [STATE_W-1:0]  state_index_i,
  input  logic [SYM_W-1:0]    input_symbol_i,
  input  logic [STATE_W-1:0]  target_state_i,
  input  logic [OSYM_W-1:0]   output_symbol_i,
  input  logic [TLEN_W-1:0]   timeout_length_i,
  output tfe_queue_t          queue_o,
  input  logic                pop_i
);

  tfe_item_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]    count_q, count_d;
  tfe_item_t            cls;
  logic                 push;
  logic                 pop;
  logic [NSTATES_W-1:0] sb;
  logic [NINPUTS_W-1:0] ib;
  logic                 idx_ok, tgt_ok, sym_ok, init_ok;

  assign sb      = state_bound(cfg_i);
  assign ib      = input_bound(cfg_i);
  assign idx_ok  = {1'b0, state_index_i} < sb;
  assign tgt_ok  = {1'b0, target_state_i} < sb;
  assign init_ok = {1'b0, cfg_i.restart_state} < sb;
  assign sym_ok  = {1'b0, input_symbol_i} < ib;

  // Range checks that depend only on the item and the configuration
  always_comb begin
    cls.state_index = state_index_i;
    cls.symbol      = input_symbol_i;
    cls.target      = target_state_i;
    cls.out_symbol  = output_symbol_i;
    cls.limit       = TIME_BITS'(timeout_length_i);
    cls.op          = OP_TICK;
    cls.bad         = 1'b1;
    case (func_i)
      OP_LOAD_TRANS: begin
        cls.op  = OP_LOAD_TRANS;
        cls.bad = !(idx_ok && sym_ok && tgt_ok);
      end
      OP_LOAD_TIME: begin
        cls.op  = OP_LOAD_TIME;
        cls.bad = !(idx_ok && tgt_ok);
      end
      OP_RESTART: begin
        cls.op     = OP_RESTART;
        cls.bad    = !init_ok;
        cls.target = cfg_i.restart_state;
      end
      OP_APPLY: begin
        cls.op  = OP_APPLY;
        cls.bad = !sym_ok;
      end
      OP_TICK: begin
        cls.op  = OP_TICK;
        cls.bad = 1'b0;
      end
      default: begin
        cls.op  = OP_TICK;
        cls.bad = 1'b1;
      end
    endcase
  end

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  assign queue_o.valid = (count_q != '0);
  assign queue_o.item  = entry_q[rd_ptr_q];

endmodule

/* src/tfe_back.sv */
module tfe_back import tfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tfe_cfg_t              cfg_i,
  input  tfe_queue_t            queue_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OSYM_W-1:0]     emitted_o,
  output logic [STATE_W-1:0]    present_state_o,
  output logic [TLEN_W-1:0]     elapsed_ticks_o,
  output logic                  bad_item_o
);

  tfe_trans_t trans_mem [TRANS_DEPTH];
  tfe_time_t  time_mem  [MAX_STATES];

  tfe_bk_state_e        state_q, state_d;
  tfe_item_t            item_q;
  tfe_trans_t           trans_rd_q;
  tfe_time_t            time_rd_q;
  logic [STATE_W-1:0]   cur_q, cur_d;
  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic                 out_valid_q, out_valid_d;
  logic [OSYM_W-1:0]    emitted_q, emitted_d;
  logic                 bad_q, bad_d;
  logic                 issue, finish, out_free;
  logic [NSTATES_W-1:0] sb;
  logic                 cur_ok;
  logic [TIME_BITS-1:0] tick_inc;
  logic [TRANS_AW-1:0]  wr_addr, rd_addr;

  function automatic logic [TRANS_AW-1:0] trans_addr(logic [STATE_W-1:0] st,
                                                     logic [SYM_W-1:0] sym);
    return TRANS_AW'(st) * TRANS_AW'(MAX_INPUTS) + TRANS_AW'(sym);
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_ISSUE:  if (queue_i.valid) state_d = BK_FINISH;
      BK_FINISH: if (out_free) state_d = BK_ISSUE;
      default:   state_d = BK_ISSUE;
    endcase
  end

  always_comb begin
    issue  = 1'b0;
    finish = 1'b0;
    case (state_q)
      BK_ISSUE:  issue  = queue_i.valid;
      BK_FINISH: finish = out_free;
      default: begin
        issue  = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  assign pop_o = issue;

  // Loads write at issue; reads use the state as it stands before this item
  assign wr_addr = trans_addr(queue_i.item.state_index, queue_i.item.symbol);
  assign rd_addr = trans_addr(cur_q, queue_i.item.symbol);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (!queue_i.item.bad && queue_i.item.op == OP_LOAD_TRANS) begin
        trans_mem[wr_addr] <= '{next_state: queue_i.item.target,
                                out_symbol: queue_i.item.out_symbol};
      end
      trans_rd_q <= trans_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (!queue_i.item.bad && queue_i.item.op == OP_LOAD_TIME) begin
        time_mem[TIME_AW'(queue_i.item.state_index)] <= '{expiry: queue_i.item.target,
                                                          limit: queue_i.item.limit};
      end
      time_rd_q <= time_mem[TIME_AW'(cur_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      item_q <= queue_i.item;
    end
  end

  assign sb       = state_bound(cfg_i);
  assign cur_ok   = {1'b0, cur_q} < sb;
  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    cur_d     = cur_q;
    tick_d    = tick_q;
    emitted_d = cfg_i.num_outputs;
    bad_d     = item_q.bad;
    case (item_q.op)
      OP_RESTART: begin
        if (!item_q.bad) begin
          cur_d  = item_q.target;
          tick_d = '0;
        end
      end
      OP_APPLY: begin
        if (item_q.bad || !cur_ok) begin
          bad_d = 1'b1;
        end else begin
          emitted_d = trans_rd_q.out_symbol;
          cur_d     = trans_rd_q.next_state;
          tick_d    = '0;
        end
      end
      OP_TICK: begin
        if (item_q.bad || !cur_ok) begin
          bad_d = 1'b1;
        end else if (tick_inc >= time_rd_q.limit) begin
          cur_d  = time_rd_q.expiry;
          tick_d = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        bad_d = item_q.bad;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_ISSUE;
      cur_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        cur_q  <= cur_d;
        tick_q <= tick_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      emitted_q <= emitted_d;
      bad_q     <= bad_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign emitted_o       = emitted_q;
  assign present_state_o = cur_q;
  assign elapsed_ticks_o = TLEN_W'(tick_q);
  assign bad_item_o      = bad_q;

endmodule

/* src/timed_fsm_engine.sv */
// The back end takes one item at a time from the queue: at issue it pops it and
// reads the transition and timeout memories at the current state, and at finish,
// held off by an output stall, it updates the state and registers the result.
// A 2-entry queue lets input items be taken while the back end is busy.
// Reset (async, active low) clears state, tick count and queue and returns
// the config registers to their reset values; tables are undefined until loaded.
module timed_fsm_engine import tfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [STATE_W-1:0]    state_index_i,
  input  logic [SYM_W-1:0]      input_symbol_i,
  input  logic [STATE_W-1:0]    target_state_i,
  input  logic [OSYM_W-1:0]     output_symbol_i,
  input  logic [TLEN_W-1:0]     timeout_length_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OSYM_W-1:0]     emitted_o,
  output logic [STATE_W-1:0]    present_state_o,
  output logic [TLEN_W-1:0]     elapsed_ticks_o,
  output logic                  bad_item_o
);

  tfe_cfg_t   cfg_q;
  tfe_queue_t queue;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_states    <= NSTATES_W'(1);
      cfg_q.num_inputs    <= NINPUTS_W'(1);
      cfg_q.num_outputs   <= NOUTPUTS_W'(1);
      cfg_q.restart_state <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NUM_STATES:    cfg_q.num_states    <= cfg_data_i;
        REG_NUM_INPUTS:    cfg_q.num_inputs    <= cfg_data_i[NINPUTS_W-1:0];
        REG_NUM_OUTPUTS:   cfg_q.num_outputs   <= cfg_data_i[NOUTPUTS_W-1:0];
        REG_RESTART_STATE: cfg_q.restart_state <= cfg_data_i[STATE_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .state_index_i    (state_index_i),
    .input_symbol_i   (input_symbol_i),
    .target_state_i   (target_state_i),
    .output_symbol_i  (output_symbol_i),
    .timeout_length_i (timeout_length_i),
    .queue_o          (queue),
    .pop_i            (pop)
  );

  tfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .queue_i         (queue),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .emitted_o       (emitted_o),
    .present_state_o (present_state_o),
    .elapsed_ticks_o (elapsed_ticks_o),
    .bad_item_o      (bad_item_o)
  );

endmodule
